FILE: design/hav_pkg.sv
`timescale 1ns / 1ps

package hav_pkg;

   // Q30 constants
   localparam int unsigned QW          = 34;  // signed datapath width for CORDIC
   localparam int unsigned STEPS       = 30;
   localparam logic [31:0] ONE_Q       = 32'd1073741824;
   localparam logic [31:0] HALF_PI_Q   = 32'd1686629713;
   localparam logic [31:0] PI_Q        = 32'd3373259426;
   localparam logic [24:0] RAD_PER_DEG = 25'd18740330;
   localparam logic [31:0] CORDIC_X0   = 32'd652032874;

   // arctangent of 2^-i in Q30
   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h3243F6A8;
         5'd1:  r = 32'h1DAC6705;
         5'd2:  r = 32'h0FADBAFC;
         5'd3:  r = 32'h07F56EA6;
         5'd4:  r = 32'h03FEAB76;
         5'd5:  r = 32'h01FFD55B;
         5'd6:  r = 32'h00FFFAAA;
         5'd7:  r = 32'h007FFF55;
         5'd8:  r = 32'h003FFFEA;
         5'd9:  r = 32'h001FFFFD;
         5'd10: r = 32'h000FFFFF;
         5'd11: r = 32'h0007FFFF;
         5'd12: r = 32'h0003FFFF;
         5'd13: r = 32'h0001FFFF;
         5'd14: r = 32'h0000FFFF;
         5'd15: r = 32'h00007FFF;
         5'd16: r = 32'h00003FFF;
         5'd17: r = 32'h00001FFF;
         5'd18: r = 32'h00000FFF;
         5'd19: r = 32'h000007FF;
         5'd20: r = 32'h000003FF;
         5'd21: r = 32'h000001FF;
         5'd22: r = 32'h000000FF;
         5'd23: r = 32'h0000007F;
         5'd24: r = 32'h0000003F;
         5'd25: r = 32'h0000001F;
         5'd26: r = 32'h0000000F;
         5'd27: r = 32'h00000008;
         5'd28: r = 32'h00000004;
         5'd29: r = 32'h00000002;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   // one CORDIC lane state
   typedef struct packed {
      logic signed [QW-1:0] x;
      logic signed [QW-1:0] y;
      logic signed [QW-1:0] z;
   } lane_type;

   // square root cell state: remainder, root, 60-bit operand shifted out
   typedef struct packed {
      logic [32:0] rem;
      logic [31:0] root;
      logic [59:0] opnd;
   } sqrt_type;

endpackage

FILE: design/hav_rot_cell.sv
`timescale 1ns / 1ps

// One CORDIC iteration (rotation or vectoring), registered.
module hav_rot_cell #(
   parameter int unsigned STEP = 0,
   parameter bit          VECTOR = 1'b0,
   parameter int unsigned NL = 4
) (
   input  logic                 clock,
   input  logic                 adv,
   input  hav_pkg::lane_type    lane_in [NL],
   output hav_pkg::lane_type    lane_out [NL]
);

   hav_pkg::lane_type lane_ff [NL];
   hav_pkg::lane_type lane_in2 [NL];
   logic signed [hav_pkg::QW-1:0] ang;

   assign ang = $signed({2'b00, hav_pkg::atan_entry(5'(STEP))});

   // rotate each lane one step toward its target
   always_comb begin
      for (int k = 0; k < NL; k++) begin
         logic pos;
         logic signed [hav_pkg::QW-1:0] dx, dy;
         dx = lane_in[k].y >>> STEP;
         dy = lane_in[k].x >>> STEP;
         pos = VECTOR ? !(lane_in[k].y > 0) : (lane_in[k].z >= 0);
         lane_in2[k] = lane_in[k];
         if (pos) begin
            lane_in2[k].x = lane_in[k].x - dx;
            lane_in2[k].y = lane_in[k].y + dy;
            lane_in2[k].z = lane_in[k].z - ang;
         end else begin
            lane_in2[k].x = lane_in[k].x + dx;
            lane_in2[k].y = lane_in[k].y - dy;
            lane_in2[k].z = lane_in[k].z + ang;
         end
      end
   end

   // advance with the pipeline
   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in2;
      end
   end

   assign lane_out = lane_ff;

endmodule

FILE: design/hav_sqrt_cell.sv
`timescale 1ns / 1ps

// One digit of a restoring square root, two lanes, registered.
module hav_sqrt_cell (
   input  logic              clock,
   input  logic              adv,
   input  hav_pkg::sqrt_type sq_in [2],
   output hav_pkg::sqrt_type sq_out [2]
);

   hav_pkg::sqrt_type sq_ff [2];
   hav_pkg::sqrt_type sq_in2 [2];

   // bring down two bits, try root*4+1
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         logic [34:0] trial;
         logic [34:0] cur;
         cur   = {sq_in[k].rem[32:0], sq_in[k].opnd[59:58]};
         trial = {1'b0, sq_in[k].root, 2'b01};
         sq_in2[k].opnd = {sq_in[k].opnd[57:0], 2'b00};
         if (cur >= trial) begin
            sq_in2[k].rem  = 33'(cur - trial);
            sq_in2[k].root = {sq_in[k].root[30:0], 1'b1};
         end else begin
            sq_in2[k].rem  = 33'(cur);
            sq_in2[k].root = {sq_in[k].root[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff <= sq_in2;
      end
   end

   assign sq_out = sq_ff;

endmodule

FILE: design/haversine_distance.sv
`timescale 1ns / 1ps

// channel | handshake           | payload
// req     | req_tvalid/tready   | tdata 128b: lat_first, lon_first, lat_second, lon_second
// rsp     | rsp_tvalid/tready   | tdata 80b: central_angle, distance
// csr     | csr_we              | csr_wdata 24b: sphere_radius
//
// One item per cycle while rsp is not stalled; the path from accept to rsp_tvalid
// has 3 input stages, 30 sine/cosine cells, 6 product stages, 31 square root stages,
// 31 arctangent stages and 3 stages of cap, double and distance multiply.
// The whole chain advances only while the final output register is free or
// being read, so a stall on rsp holds every cell. Reset is synchronous; it
// clears the valid bits and sets the radius to 6371.
module haversine_distance #(
   parameter int unsigned DEGREE_FRAC_BITS = 22
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // lat_first[29:0], lon_first[60:30],
                                    // lat_second[90:61], lon_second[121:91]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata,  // central_angle[31:0], distance[73:32]
   input  logic         csr_we,
   input  logic [23:0]  csr_wdata
);

   localparam int unsigned QW    = hav_pkg::QW;
   localparam int unsigned NST   = hav_pkg::STEPS;
   localparam int unsigned DEPTH = 3 + NST + 6 + 31 + 1 + NST + 3;

   logic [23:0] radius_ff;
   logic [DEPTH-1:0] vld_ff;
   logic adv;

   // chain moves when the last slot is empty or being taken
   assign adv        = !vld_ff[DEPTH-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 24'd6371;
         vld_ff    <= '0;
      end else begin
         if (csr_we) radius_ff <= csr_wdata;
         if (adv) vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
      end
   end

   // ---- stage 1: clamp and differences
   localparam logic signed [32:0] LAT_MAX = 33'sd90 <<< DEGREE_FRAC_BITS;
   localparam logic signed [32:0] LON_MAX = 33'sd180 <<< DEGREE_FRAC_BITS;

   function automatic logic signed [32:0] clampv(input logic signed [32:0] v,
                                                 input logic signed [32:0] m);
      if (v > m) return m;
      if (v < -m) return -m;
      return v;
   endfunction

   function automatic logic [32:0] absv(input logic signed [33:0] v);
      logic signed [33:0] a;
      a = (v < 0) ? -v : v;
      return a[32:0];
   endfunction

   logic signed [32:0] la1, lo1, la2, lo2;
   logic [32:0] m_ff [4];  // |dlat|, |dlon|, |lat1|, |lat2|

   assign la1 = clampv(33'(signed'(req_tdata[29:0])), LAT_MAX);
   assign lo1 = clampv(33'(signed'(req_tdata[60:30])), LON_MAX);
   assign la2 = clampv(33'(signed'(req_tdata[90:61])), LAT_MAX);
   assign lo2 = clampv(33'(signed'(req_tdata[121:91])), LON_MAX);

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff[0] <= absv(34'(la2) - 34'(la1));
         m_ff[1] <= absv(34'(lo2) - 34'(lo1));
         m_ff[2] <= absv(34'(la1));
         m_ff[3] <= absv(34'(la2));
      end
   end

   // ---- stage 2: multiply into radians
   logic [57:0] p_ff [4];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) p_ff[k] <= 58'(m_ff[k]) * 58'(hav_pkg::RAD_PER_DEG);
      end
   end

   // ---- stage 3: round, shift, cap, fold
   logic [57:0] r_in [4];
   hav_pkg::lane_type lane0 [4];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         int unsigned s;
         s = (k < 2) ? DEGREE_FRAC_BITS + 1 : DEGREE_FRAC_BITS;
         r_in[k] = (p_ff[k] + (58'd1 << (s - 1))) >> s;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            logic [57:0] v;
            v = r_in[k];
            if (k == 1) begin
               if (v > 58'(hav_pkg::PI_Q)) v = 58'(hav_pkg::PI_Q);
               if (v > 58'(hav_pkg::HALF_PI_Q)) v = 58'(hav_pkg::PI_Q) - v;
            end else if (v > 58'(hav_pkg::HALF_PI_Q)) begin
               v = 58'(hav_pkg::HALF_PI_Q);
            end
            lane0[k].x <= QW'(hav_pkg::CORDIC_X0);
            lane0[k].y <= '0;
            lane0[k].z <= QW'(v);
         end
      end
   end

   // ---- sine/cosine chain
   hav_pkg::lane_type rl [NST+1][4];
   assign rl[0] = lane0;
   for (genvar g = 0; g < NST; g++) begin : g_rot
      hav_rot_cell #(.STEP(g), .VECTOR(1'b0), .NL(4)) u_cell (
         .clock(clock), .adv(adv), .lane_in(rl[g]), .lane_out(rl[g+1]));
   end

   function automatic logic [30:0] cap01(input logic signed [QW-1:0] v);
      if (v < 0) return '0;
      if (v > QW'(hav_pkg::ONE_Q)) return 31'(hav_pkg::ONE_Q);
      return v[30:0];
   endfunction

   // ---- products: s1^2, c1*c2, s2^2 then (c1c2)*(s2^2)
   logic [30:0] s1_ff, s2_ff, c1_ff, c2_ff;
   logic [61:0] q1_ff, q2_ff, q3_ff;
   logic [30:0] t1_ff, t2_ff, t3_ff;
   logic [61:0] q4_ff;
   logic [30:0] t1b_ff, t1c_ff, t4_ff;
   logic [31:0] h_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= cap01(rl[NST][0].y);
         s2_ff <= cap01(rl[NST][1].y);
         c1_ff <= cap01(rl[NST][2].x);
         c2_ff <= cap01(rl[NST][3].x);
         q1_ff <= 62'(s1_ff) * 62'(s1_ff);
         q2_ff <= 62'(c1_ff) * 62'(c2_ff);
         q3_ff <= 62'(s2_ff) * 62'(s2_ff);
         t1_ff <= 31'((q1_ff + (62'd1 << 29)) >> 30);
         t2_ff <= 31'((q2_ff + (62'd1 << 29)) >> 30);
         t3_ff <= 31'((q3_ff + (62'd1 << 29)) >> 30);
         q4_ff  <= 62'(t2_ff) * 62'(t3_ff);
         t1b_ff <= t1_ff;
         t1c_ff <= t1b_ff;
         t4_ff  <= 31'((q4_ff + (62'd1 << 29)) >> 30);
         begin
            logic [31:0] hs;
            hs = 32'(t1c_ff) + 32'(t4_ff);
            h_ff <= (hs > hav_pkg::ONE_Q) ? hav_pkg::ONE_Q : hs;
         end
      end
   end
   // t1 is delayed two stages to line up with t4
   // (t1_ff -> t1b_ff -> t1c_ff while t2,t3 -> q4 -> t4)

   // ---- square roots of h and 1-h, operand value<<30 (61 bits, pad to 62)
   // h is at most 2^30 so (h<<30) fits 61 bits: top digit pair is {h[31:30]}
   hav_pkg::sqrt_type sq_top [2];
   always_comb begin
      logic [31:0] om;
      om = hav_pkg::ONE_Q - h_ff;
      sq_top[0].rem  = {31'd0, h_ff[31:30]};
      sq_top[0].root = 32'(h_ff[31:30] != 2'd0);
      sq_top[0].opnd = {h_ff[29:0], 30'd0};
      sq_top[1].rem  = {31'd0, om[31:30]};
      sq_top[1].root = 32'(om[31:30] != 2'd0);
      sq_top[1].opnd = {om[29:0], 30'd0};
      for (int k = 0; k < 2; k++) begin
         if (sq_top[k].root[0]) sq_top[k].rem = sq_top[k].rem - 33'd1;
      end
   end

   hav_pkg::sqrt_type sqc [31][2];
   always_ff @(posedge clock) begin
      if (adv) sqc[0] <= sq_top;
   end
   for (genvar g = 0; g < 30; g++) begin : g_sqrt
      hav_sqrt_cell u_sq (.clock(clock), .adv(adv), .sq_in(sqc[g]), .sq_out(sqc[g+1]));
   end

   // ---- arctangent chain
   hav_pkg::lane_type al [NST+1][1];
   always_ff @(posedge clock) begin
      if (adv) begin
         al[0][0].x <= QW'(sqc[30][1].root);
         al[0][0].y <= QW'(sqc[30][0].root);
         al[0][0].z <= '0;
      end
   end
   for (genvar g = 0; g < NST; g++) begin : g_atan
      hav_rot_cell #(.STEP(g), .VECTOR(1'b1), .NL(1)) u_cell (
         .clock(clock), .adv(adv), .lane_in(al[g]), .lane_out(al[g+1]));
   end

   // ---- cap, double, scale by radius
   logic [31:0] ang_ff, ang2_ff, ang3_ff;
   logic [55:0] dprod_ff;
   logic [41:0] dist_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         begin
            logic signed [QW-1:0] z;
            z = al[NST][0].z;
            if (z < 0) ang_ff <= '0;
            else if (z > QW'(hav_pkg::HALF_PI_Q)) ang_ff <= hav_pkg::PI_Q;
            else ang_ff <= {z[30:0], 1'b0};
         end
         dprod_ff <= 56'(radius_ff) * 56'(ang_ff);
         ang2_ff  <= ang_ff;
         dist_ff  <= 42'((dprod_ff + 56'd8192) >> 14);
         ang3_ff  <= ang2_ff;
      end
   end

   assign rsp_tdata = {6'd0, dist_ff, ang3_ff};

endmodule

FILE: design/hav_check.sv
`timescale 1ns / 1ps

module hav_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item dropped");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:0] <= 32'd3373259426)
      else $error("angle out of range");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("accepted while stalled");
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("valid after reset");

endmodule

bind haversine_distance hav_check u_chk (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int LATENCY   = 120;
   localparam int N_RANDOM  = 412;
   localparam int MAX_CYCLE = 400000;
   localparam longint LAT_MAX = 64'sd90 <<< 22;
   localparam longint LON_MAX = 64'sd180 <<< 22;

   typedef struct {
      logic [29:0] lat1;
      logic [30:0] lon1;
      logic [29:0] lat2;
      logic [30:0] lon2;
   } point_pair_type;

   typedef struct {
      logic [31:0] angle;
      logic [41:0] span;
   } arc_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic [23:0]  csr_wdata = '0;

   arc_type        arc_queue[$];
   longint         radius;
   int             fail_count = 0;
   int             arc_count = 0;
   int             cycle = 0;
   bit             rx_idle_on = 1'b1;
   bit             tx_idle_on = 1'b1;
   bit             hold_rx = 1'b0;
   point_pair_type vectors[$];

   haversine_distance dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint to_rad(longint mag, int extra);
      int s;
      s = 22 + extra;
      return (mag * 64'd18740330 + (64'd1 << (s - 1))) >> s;
   endfunction

   function automatic void rotate(longint z, output longint sn, output longint cs);
      longint x, y, dx, dy;
      x = 64'd652032874;
      y = 0;
      for (int i = 0; i < hav_pkg::STEPS; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(hav_pkg::atan_entry(5'(i)));
         end else begin
            x += dx; y -= dy; z += longint'(hav_pkg::atan_entry(5'(i)));
         end
      end
      sn = clip(y, 0, 64'd1 << 30);
      cs = clip(x, 0, 64'd1 << 30);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b + (64'd1 << 29)) >> 30;
   endfunction

   function automatic longint root(longint n);
      longint res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w >>= 2;
      while (bit_w != 0) begin
         if (n >= res + bit_w) begin
            n -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res;
   endfunction

   function automatic longint vector_angle(longint p, longint q);
      longint x, y, z, dx, dy;
      x = q; y = p; z = 0;
      for (int i = 0; i < hav_pkg::STEPS; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += longint'(hav_pkg::atan_entry(5'(i)));
         end else begin
            x -= dx; y += dy; z -= longint'(hav_pkg::atan_entry(5'(i)));
         end
      end
      return clip(z, 0, 64'd1686629713);
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic arc_type great_circle(point_pair_type pp, longint r);
      longint la1, lo1, la2, lo2, a, b, r1, r2, s1, s2, c1, c2, unused, h, p, q, ang;
      arc_type o;
      la1 = clip(longint'(signed'(pp.lat1)), -LAT_MAX, LAT_MAX);
      lo1 = clip(longint'(signed'(pp.lon1)), -LON_MAX, LON_MAX);
      la2 = clip(longint'(signed'(pp.lat2)), -LAT_MAX, LAT_MAX);
      lo2 = clip(longint'(signed'(pp.lon2)), -LON_MAX, LON_MAX);
      a = clip(to_rad(mag(la2 - la1), 1), 0, 64'd1686629713);
      b = clip(to_rad(mag(lo2 - lo1), 1), 0, 64'd3373259426);
      if (b > 64'd1686629713) b = 64'd3373259426 - b;
      r1 = clip(to_rad(mag(la1), 0), 0, 64'd1686629713);
      r2 = clip(to_rad(mag(la2), 0), 0, 64'd1686629713);
      rotate(a, s1, unused);
      rotate(b, s2, unused);
      rotate(r1, unused, c1);
      rotate(r2, unused, c2);
      h = qmul(s1, s1) + qmul(qmul(c1, c2), qmul(s2, s2));
      if (h > (64'd1 << 30)) h = 64'd1 << 30;
      p = root(h << 30);
      q = root(((64'd1 << 30) - h) << 30);
      ang = vector_angle(p, q) * 2;
      o.angle = ang[31:0];
      o.span = 42'((r * ang + (64'd1 << 13)) >> 14);
      return o;
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle);
      fail_count++;
   endtask

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         arc_count++;
         if (arc_queue.size() == 0) begin
            report_mismatch("unexpected item", rsp_tdata[31:0], 0);
         end else begin
            if (rsp_tdata[31:0] !== arc_queue[0].angle)
               report_mismatch("central_angle", rsp_tdata[31:0], arc_queue[0].angle);
            if (rsp_tdata[73:32] !== arc_queue[0].span)
               report_mismatch("distance", rsp_tdata[73:32], arc_queue[0].span);
            void'(arc_queue.pop_front());
         end
      end
   end

   // Receiver: random stall bursts, plus an optional long hold-off.
   initial begin : receiver
      int n;
      forever begin
         @(posedge clock);
         if (hold_rx) begin
            rsp_tready <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 5);
            rsp_tready <= 1'b0;
            repeat (n - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Abort on runaway.
   always @(posedge clock) begin
      if (cycle > MAX_CYCLE) begin
         $display("timeout at cycle %0d", cycle);
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   // Valid stays high after an accept; drain() drops it, and so does the next call when it inserts an idle gap.
   task automatic send_pair(point_pair_type pp);
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, pp.lon2, pp.lat2, pp.lon1, pp.lat1};
      arc_queue.push_back(great_circle(pp, radius));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (arc_queue.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic set_radius(logic [23:0] r);
      csr_we <= 1'b1;
      csr_wdata <= r;
      @(posedge clock);
      csr_we <= 1'b0;
      radius = r;
   endtask

   function automatic point_pair_type make_pair(longint a, longint b, longint c,
                                                longint d);
      point_pair_type pp;
      pp.lat1 = a[29:0]; pp.lon1 = b[30:0]; pp.lat2 = c[29:0]; pp.lon2 = d[30:0];
      return pp;
   endfunction

   function automatic point_pair_type random_pair();
      point_pair_type pp;
      case ($urandom_range(0, 7))
         // raw bits, including out-of-range coordinates
         0: pp = make_pair($urandom, $urandom, $urandom, $urandom);
         // nearby points
         1: begin
            pp = make_pair($signed($urandom_range(0, 754974720)) - 377487360,
                           $signed($urandom_range(0, 1509949440)) - 754974720, 0, 0);
            pp.lat2 = pp.lat1 + 30'($urandom_range(0, 4096)) - 30'd2048;
            pp.lon2 = pp.lon1 + 31'($urandom_range(0, 4096)) - 31'd2048;
         end
         default:
            pp = make_pair(longint'($urandom_range(0, 754974720)) - 377487360,
                           longint'($urandom_range(0, 1509949440)) - 754974720,
                           longint'($urandom_range(0, 754974720)) - 377487360,
                           longint'($urandom_range(0, 1509949440)) - 754974720);
      endcase
      return pp;
   endfunction

   task automatic load_vectors();
      // identical points
      vectors.push_back(make_pair(0, 0, 0, 0));
      vectors.push_back(make_pair(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX));
      // poles, antimeridian and antipodes
      vectors.push_back(make_pair(LAT_MAX, 0, -LAT_MAX, 0));
      vectors.push_back(make_pair(0, -LON_MAX, 0, LON_MAX));
      vectors.push_back(make_pair(0, 0, 0, LON_MAX));
      vectors.push_back(make_pair(0, -LON_MAX, 0, 0));
      vectors.push_back(make_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX));
      // out-of-range coordinates saturate
      vectors.push_back(make_pair(-(64'sd1 <<< 29), -(64'sd1 <<< 30),
                                  (64'sd1 <<< 29) - 1, (64'sd1 <<< 30) - 1));
      vectors.push_back(make_pair((64'sd1 <<< 29) - 1, 0, 0, -(64'sd1 <<< 30)));
      vectors.push_back(make_pair(1, 1, 0, 0));
      vectors.push_back(make_pair(-1, -1, -1, 0));
      vectors.push_back(make_pair(64'sd45 <<< 22, 64'sd90 <<< 22,
                                  -(64'sd45 <<< 22), -(64'sd90 <<< 22)));
      vectors.push_back(make_pair(64'sd30 <<< 22, 64'sd179 <<< 22,
                                  64'sd30 <<< 22, -(64'sd179 <<< 22)));
   endtask

   initial begin : main
      point_pair_type pp;
      radius = 6371;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at the reset radius.
      load_vectors();
      foreach (vectors[i]) send_pair(vectors[i]);
      drain();

      // Extreme radius settings.
      set_radius(24'd1);
      foreach (vectors[i]) send_pair(vectors[i]);
      drain();
      set_radius(24'hFFFFFF);
      foreach (vectors[i]) send_pair(vectors[i]);
      drain();

      // Random phases, each with its own radius; one phase with a long hold-off.
      for (int ph = 0; ph < 4; ph++) begin
         set_radius(ph == 3 ? 24'd6371 : 24'($urandom_range(1, 24'hFFFFFF)));
         if (ph == 1) begin
            fork
               begin
                  hold_rx = 1'b1;
                  repeat (400) @(posedge clock);
                  hold_rx = 1'b0;
               end
            join_none
         end
         if (ph == 3) begin
            rx_idle_on = 1'b0;
            tx_idle_on = 1'b0;
         end
         for (int k = 0; k < N_RANDOM / 4; k++) begin
            pp = random_pair();
            send_pair(pp);
         end
         drain();
      end

      $display("Covered %0d results across directed extremes, saturation and random pairs",
               arc_count);
      $display("at several radius settings, with stall bursts and a long output hold-off.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/hav_pkg.sv
design/hav_rot_cell.sv
design/hav_sqrt_cell.sv
design/haversine_distance.sv
design/hav_check.sv
verif/tb.sv
